// ===== rtl/tvg_pkg.sv =====
// Shared types, constants and the fixed-point sine function of the torus vertex generator.
package tvg_pkg;

  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int ANGLE_BITS_DEF   = 10;

  localparam int CFG_W    = 15;
  localparam int COUNT_W  = 9;
  localparam int FIELD_W  = 16;

  localparam logic [14:0] INNER_RESET = 15'd1126;
  localparam logic [14:0] OUTER_RESET = 15'd3482;
  localparam logic [8:0]  SIDES_RESET = 9'd20;
  localparam logic [8:0]  RINGS_RESET = 9'd20;

  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  localparam logic [14:0] QSINE [33] = '{
    15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,  15'd5520,
    15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,  15'd10394, 15'd11003,
    15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623, 15'd14053, 15'd14449, 15'd14811,
    15'd15137, 15'd15426, 15'd15679, 15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364,
    15'd16384
  };

  typedef enum logic [1:0] {
    REG_INNER = 2'd0,
    REG_OUTER = 2'd1,
    REG_SIDES = 2'd2,
    REG_RINGS = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV_RING, S_TRIG_NC, S_TRIG_NS, S_DIV_SIDE,
    S_TRIG_C, S_TRIG_S, S_MUL, S_OUT1, S_OUT2
  } state_t;

  typedef enum logic [2:0] {
    TRIG_NONE, TRIG_NEXT_COS, TRIG_NEXT_SIN, TRIG_SIDE_COS, TRIG_SIDE_SIN
  } trig_op_t;

  typedef enum logic [3:0] {
    MUL_DIST, MUL_ZPOS,
    MUL_NX_N, MUL_NY_N, MUL_PX_N, MUL_PY_N,
    MUL_NX_C, MUL_NY_C, MUL_PX_C, MUL_PY_C
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    logic     div_ring;
    trig_op_t trig_op;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_out;
    logic     out_second;
    logic     commit;
  } tvg_cmd_t;

  typedef struct packed {
    logic side_zero;
    logic div_busy;
    logic out_free;
  } tvg_status_t;

  // Quarter-wave sine with linear interpolation, input 0..16384.
  function automatic logic [14:0] qsin(input logic [14:0] u);
    logic [5:0]  i;
    logic [8:0]  f;
    logic [9:0]  diff;
    logic [19:0] prod;
    begin
      i = u[14:9];
      f = u[8:0];
      if (i >= 6'd32) begin
        qsin = 15'd16384;
      end else begin
        diff = 10'(QSINE[i + 6'd1] - QSINE[i]);
        prod = 20'(diff) * 20'(f) + 20'd256;
        qsin = QSINE[i] + 15'(prod[19:9]);
      end
    end
  endfunction

  // Sine of a 16-bit phase (full turn = 65536), Q1.14 result.
  function automatic logic signed [15:0] sin16(input logic [15:0] p);
    logic [13:0]        r;
    logic [14:0]        m;
    logic signed [15:0] ms;
    begin
      r = p[13:0];
      if (p[14]) begin
        m = qsin(15'(15'd16384 - {1'b0, r}));
      end else begin
        m = qsin({1'b0, r});
      end
      ms = signed'({1'b0, m});
      sin16 = p[15] ? -ms : ms;
    end
  endfunction

endpackage

// ===== rtl/tvg_controller.sv =====
// Sequencing state machine of the torus vertex generator.
module tvg_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tvg_pkg::tvg_status_t status,
  output tvg_pkg::tvg_cmd_t   cmd
);

  tvg_pkg::state_t   state_r, state_nxt;
  tvg_pkg::mul_sel_t mul_idx_r, mul_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tvg_pkg::S_IDLE;
      mul_idx_r <= tvg_pkg::MUL_DIST;
    end else begin
      state_r   <= state_nxt;
      mul_idx_r <= mul_idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mul_idx_nxt = mul_idx_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.trig_op = tvg_pkg::TRIG_NONE;
    cmd.mul_sel = mul_idx_r;
    unique case (state_r)
      tvg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = tvg_pkg::S_CHECK;
        end
      end
      tvg_pkg::S_CHECK: begin
        cmd.div_start = 1'b1;
        if (status.side_zero) begin
          cmd.div_ring = 1'b1;
          state_nxt    = tvg_pkg::S_DIV_RING;
        end else begin
          state_nxt = tvg_pkg::S_DIV_SIDE;
        end
      end
      tvg_pkg::S_DIV_RING: begin
        if (!status.div_busy) state_nxt = tvg_pkg::S_TRIG_NC;
      end
      tvg_pkg::S_TRIG_NC: begin
        cmd.trig_op = tvg_pkg::TRIG_NEXT_COS;
        state_nxt   = tvg_pkg::S_TRIG_NS;
      end
      tvg_pkg::S_TRIG_NS: begin
        cmd.trig_op   = tvg_pkg::TRIG_NEXT_SIN;
        cmd.div_start = 1'b1;
        state_nxt     = tvg_pkg::S_DIV_SIDE;
      end
      tvg_pkg::S_DIV_SIDE: begin
        if (!status.div_busy) state_nxt = tvg_pkg::S_TRIG_C;
      end
      tvg_pkg::S_TRIG_C: begin
        cmd.trig_op = tvg_pkg::TRIG_SIDE_COS;
        state_nxt   = tvg_pkg::S_TRIG_S;
      end
      tvg_pkg::S_TRIG_S: begin
        cmd.trig_op = tvg_pkg::TRIG_SIDE_SIN;
        mul_idx_nxt = tvg_pkg::MUL_DIST;
        state_nxt   = tvg_pkg::S_MUL;
      end
      tvg_pkg::S_MUL: begin
        cmd.mul_en  = 1'b1;
        mul_idx_nxt = tvg_pkg::mul_sel_t'(mul_idx_r + 4'd1);
        if (mul_idx_r == tvg_pkg::MUL_PY_N) begin
          state_nxt = tvg_pkg::S_OUT1;
        end else if (mul_idx_r == tvg_pkg::MUL_PY_C) begin
          state_nxt = tvg_pkg::S_OUT2;
        end
      end
      tvg_pkg::S_OUT1: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = tvg_pkg::S_MUL;
        end
      end
      tvg_pkg::S_OUT2: begin
        if (status.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_second = 1'b1;
          cmd.commit     = 1'b1;
          state_nxt      = tvg_pkg::S_IDLE;
        end
      end
      default: state_nxt = tvg_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/tvg_datapath.sv =====
// Datapath of the torus vertex generator: registers, divider, sine unit, multiplier, output.
module tvg_datapath #(
  parameter int MAX_SEGMENTS = tvg_pkg::MAX_SEGMENTS_DEF,
  parameter int ANGLE_BITS   = tvg_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_wdata,
  input  logic                in_restart,
  input  tvg_pkg::tvg_cmd_t   cmd,
  output tvg_pkg::tvg_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_normal_x,
  output logic signed [15:0]  out_normal_y,
  output logic signed [15:0]  out_normal_z,
  output logic signed [15:0]  out_pos_x,
  output logic signed [15:0]  out_pos_y,
  output logic signed [15:0]  out_pos_z,
  output logic                out_strip_end,
  output logic                out_mesh_end,
  output logic                out_pair_last
);

  localparam int NW     = $clog2(MAX_SEGMENTS + 1);
  localparam int KW     = NW + 1;
  localparam int DW     = KW + ANGLE_BITS;
  localparam int CNTW   = $clog2(DW + 1);
  localparam int PH_PAD = 16 - ANGLE_BITS;

  logic [14:0] inner_r, outer_r;
  logic [8:0]  sides_r, rings_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= tvg_pkg::INNER_RESET;
      outer_r <= tvg_pkg::OUTER_RESET;
      sides_r <= tvg_pkg::SIDES_RESET;
      rings_r <= tvg_pkg::RINGS_RESET;
    end else if (cfg_we) begin
      unique case (tvg_pkg::cfg_reg_t'(cfg_index))
        tvg_pkg::REG_INNER: inner_r <= cfg_wdata;
        tvg_pkg::REG_OUTER: outer_r <= cfg_wdata;
        tvg_pkg::REG_SIDES: sides_r <= cfg_wdata[8:0];
        tvg_pkg::REG_RINGS: rings_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] ns, nr;
  always_comb begin
    if (sides_r < 9'd3) ns = NW'(3);
    else if (32'(sides_r) > MAX_SEGMENTS) ns = NW'(MAX_SEGMENTS);
    else ns = NW'(sides_r);
    if (rings_r < 9'd3) nr = NW'(3);
    else if (32'(rings_r) > MAX_SEGMENTS) nr = NW'(MAX_SEGMENTS);
    else nr = NW'(rings_r);
  end

  // Mesh position and ring trig values.
  logic [NW-1:0]      ring_r, side_r;
  logic signed [15:0] cos_cur_r, sin_cur_r, cos_next_r, sin_next_r;
  logic signed [15:0] cp_r, sp_r;
  logic               last_side, last_ring;

  assign last_side = side_r >= ns;
  assign last_ring = (KW'(ring_r) + KW'(1)) >= KW'(nr);

  // Serial long division of k * 2^ANGLE_BITS by the count.
  logic                  div_busy_r;
  logic [CNTW-1:0]       div_cnt_r;
  logic [DW-1:0]         div_num_r;
  logic [NW-1:0]         div_rem_r, div_den_r;
  logic [ANGLE_BITS-1:0] div_quo_r;
  logic [NW:0]           rem_sh;
  logic                  qbit;
  logic [KW-1:0]         div_k;

  assign div_k  = (cmd.div_ring ? KW'(ring_r) : KW'(side_r)) + KW'(1);
  assign rem_sh = {div_rem_r, div_num_r[DW-1]};
  assign qbit   = rem_sh >= {1'b0, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && div_cnt_r == CNTW'(1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num_r <= {div_k, ANGLE_BITS'(0)};
      div_den_r <= cmd.div_ring ? nr : ns;
      div_rem_r <= '0;
      div_cnt_r <= CNTW'(DW);
      div_quo_r <= '0;
    end else if (div_busy_r) begin
      div_num_r <= {div_num_r[DW-2:0], 1'b0};
      div_rem_r <= qbit ? NW'(rem_sh - {1'b0, div_den_r}) : rem_sh[NW-1:0];
      div_quo_r <= {div_quo_r[ANGLE_BITS-2:0], qbit};
      div_cnt_r <= div_cnt_r - CNTW'(1);
    end
  end

  // Sine unit.
  logic [15:0]        phase, trig_arg;
  logic signed [15:0] trig_val;

  assign phase = {div_quo_r, PH_PAD'(0)};
  always_comb begin
    if (cmd.trig_op == tvg_pkg::TRIG_NEXT_COS || cmd.trig_op == tvg_pkg::TRIG_SIDE_COS) begin
      trig_arg = phase + 16'd16384;
    end else begin
      trig_arg = phase;
    end
  end
  assign trig_val = tvg_pkg::sin16(trig_arg);

  // Shared multiplier with half-up rounding to Q.14.
  logic signed [17:0] dist_r;
  logic signed [15:0] zpos_r;
  logic signed [15:0] stg_nx_r, stg_ny_r, stg_px_r, stg_py_r;
  logic signed [17:0] ma, mb, inner_s, cp_s, sp_s;
  logic signed [35:0] prod, rsum;
  logic signed [21:0] rnd;
  logic signed [15:0] rnd_sat;

  assign inner_s = signed'({3'b000, inner_r});
  assign cp_s    = 18'(cp_r);
  assign sp_s    = 18'(sp_r);

  always_comb begin
    ma = 18'(cos_next_r);
    mb = cp_s;
    case (cmd.mul_sel)
      tvg_pkg::MUL_DIST: begin ma = inner_s;            mb = cp_s;   end
      tvg_pkg::MUL_ZPOS: begin ma = inner_s;            mb = sp_s;   end
      tvg_pkg::MUL_NX_N: begin ma = 18'(cos_next_r);    mb = cp_s;   end
      tvg_pkg::MUL_NY_N: begin ma = -18'(sin_next_r);   mb = cp_s;   end
      tvg_pkg::MUL_PX_N: begin ma = 18'(cos_next_r);    mb = dist_r; end
      tvg_pkg::MUL_PY_N: begin ma = -18'(sin_next_r);   mb = dist_r; end
      tvg_pkg::MUL_NX_C: begin ma = 18'(cos_cur_r);     mb = cp_s;   end
      tvg_pkg::MUL_NY_C: begin ma = -18'(sin_cur_r);    mb = cp_s;   end
      tvg_pkg::MUL_PX_C: begin ma = 18'(cos_cur_r);     mb = dist_r; end
      tvg_pkg::MUL_PY_C: begin ma = -18'(sin_cur_r);    mb = dist_r; end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign rsum = prod + 36'sd8192;
  assign rnd  = rsum[35:14];

  always_comb begin
    if (rnd > 22'sd32767) rnd_sat = 16'sh7fff;
    else if (rnd < -22'sd32768) rnd_sat = -16'sh8000;
    else rnd_sat = rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        tvg_pkg::MUL_DIST: dist_r <= 18'(outer_r) + rnd[17:0];
        tvg_pkg::MUL_ZPOS: zpos_r <= rnd[15:0];
        tvg_pkg::MUL_NX_N, tvg_pkg::MUL_NX_C: stg_nx_r <= rnd[15:0];
        tvg_pkg::MUL_NY_N, tvg_pkg::MUL_NY_C: stg_ny_r <= rnd[15:0];
        tvg_pkg::MUL_PX_N, tvg_pkg::MUL_PX_C: stg_px_r <= rnd_sat;
        tvg_pkg::MUL_PY_N, tvg_pkg::MUL_PY_C: stg_py_r <= rnd_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.trig_op)
      tvg_pkg::TRIG_SIDE_COS: cp_r <= trig_val;
      tvg_pkg::TRIG_SIDE_SIN: sp_r <= trig_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r     <= '0;
      side_r     <= '0;
      cos_cur_r  <= tvg_pkg::Q14_ONE;
      sin_cur_r  <= '0;
      cos_next_r <= '0;
      sin_next_r <= '0;
    end else begin
      if (cmd.accept && in_restart) begin
        ring_r    <= '0;
        side_r    <= '0;
        cos_cur_r <= tvg_pkg::Q14_ONE;
        sin_cur_r <= '0;
      end
      if (cmd.trig_op == tvg_pkg::TRIG_NEXT_COS) cos_next_r <= trig_val;
      if (cmd.trig_op == tvg_pkg::TRIG_NEXT_SIN) sin_next_r <= trig_val;
      if (cmd.commit) begin
        if (last_side) begin
          side_r    <= '0;
          cos_cur_r <= cos_next_r;
          sin_cur_r <= sin_next_r;
          ring_r    <= last_ring ? '0 : ring_r + NW'(1);
        end else begin
          side_r <= side_r + NW'(1);
        end
      end
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_normal_x  <= stg_nx_r;
      out_normal_y  <= stg_ny_r;
      out_normal_z  <= sp_r;
      out_pos_x     <= stg_px_r;
      out_pos_y     <= stg_py_r;
      out_pos_z     <= zpos_r;
      out_strip_end <= cmd.out_second && last_side;
      out_mesh_end  <= cmd.out_second && last_side && last_ring;
      out_pair_last <= cmd.out_second;
    end
  end

  assign out_valid        = out_valid_r;
  assign status.side_zero = side_r == '0;
  assign status.div_busy  = div_busy_r;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/torus_vertex_generator_core.sv =====
// Top level of the torus vertex generator: controller plus datapath.
//
//   Channel  Signals                                   Direction  Transfer when
//   in       in_valid, in_ready, in_restart            input      in_valid && in_ready
//   out      out_valid, out_ready, out_normal_*, ...   output     out_valid && out_ready
//   cfg      cfg_we, cfg_index, cfg_wdata              input      cfg_we
//
// Each input transfer yields two output transfers: the vertex on the next ring angle,
// then the vertex on the current ring angle. An item passes through the accept and
// check steps, the serial angle divider, the cosine and sine lookups, ten products
// through the one shared multiplier and two output loads. The first pair of a strip
// also divides and looks up the next ring's angle before its own side angle.
// Reset is synchronous and active low; it restores the register defaults and ring 0.
// A stalled output holds the vertex in the output register; the next vertex is
// computed meanwhile and waits in staging registers, and a new input is taken as soon
// as the second vertex of the previous item is in the output register.
module torus_vertex_generator_core #(
  parameter int MAX_SEGMENTS = tvg_pkg::MAX_SEGMENTS_DEF,
  parameter int ANGLE_BITS   = tvg_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic               out_strip_end,
  output logic               out_mesh_end,
  output logic               out_pair_last
);

  // The controller steps the datapath through division, sine lookup and the
  // multiply sequence; the datapath reports only divider, position and output status.
  tvg_pkg::tvg_cmd_t    cmd;
  tvg_pkg::tvg_status_t status;

  tvg_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tvg_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_restart    (in_restart),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y),
    .out_normal_z  (out_normal_z),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_strip_end (out_strip_end),
    .out_mesh_end  (out_mesh_end),
    .out_pair_last (out_pair_last)
  );

endmodule

// ===== tb/sv/tvg_checker.sv =====
// Checker for the torus vertex generator: predicts each vertex pair and compares results.
`timescale 1ns / 100ps
module tvg_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_restart,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic signed [15:0] out_normal_z,
  input  logic signed [15:0] out_pos_x,
  input  logic signed [15:0] out_pos_y,
  input  logic signed [15:0] out_pos_z,
  input  logic               out_strip_end,
  input  logic               out_mesh_end,
  input  logic               out_pair_last,
  output int                 fail_count,
  output int                 pending,
  output int                 vertex_count,
  output int                 mesh_count
);
  import tvg_pkg::*;

  typedef struct packed {
    logic signed [15:0] nx, ny, nz, px, py, pz;
    logic               strip_end, mesh_end, pair_last;
  } vertex_t;

  localparam int MAXSEG = 256;
  localparam int ABITS  = 10;

  vertex_t vertex_q[$];

  logic [14:0] inner_r, outer_r;
  logic [8:0]  sides, rings;
  int unsigned ring_pos, side_pos;
  int          cur_cos, cur_sin, nxt_cos, nxt_sin;

  int quarter_tab[33] = '{0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
    8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623, 14053, 14449,
    14811, 15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364, 16384};

  function automatic int quarter_wave(int unsigned u);
    int unsigned i, f;
    i = u >> 9;
    f = u & 511;
    if (i >= 32) return 16384;
    return quarter_tab[i] + ((((quarter_tab[i+1] - quarter_tab[i]) * f) + 256) >> 9);
  endfunction

  function automatic int sine_of(int unsigned p);
    int unsigned q, r;
    int m;
    p = p & 16'hFFFF;
    q = p >> 14;
    r = p & 16'h3FFF;
    m = q[0] ? quarter_wave(16384 - r) : quarter_wave(r);
    return q[1] ? -m : m;
  endfunction

  function automatic int unsigned angle_of(int unsigned k, int unsigned n);
    int unsigned a;
    a = ((k % n) << ABITS) / n;
    return (a << (16 - ABITS)) & 16'hFFFF;
  endfunction

  function automatic int unsigned limit_count(int unsigned v);
    if (v < 3) return 3;
    if (v > MAXSEG) return MAXSEG;
    return v;
  endfunction

  // Q1.14 product rounded half toward plus infinity.
  function automatic longint round_q14(longint a, longint b);
    longint v;
    v = a * b + 8192;
    if (v >= 0) return v >>> 14;
    return -((-v + 16383) >>> 14);
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic vertex_t make_vertex(int ct, int st, int cp, int sp, longint radial,
                                          longint zpos, logic se, logic me, logic pl);
    vertex_t v;
    v.nx = 16'(round_q14(ct, cp));
    v.ny = 16'(round_q14(-st, cp));
    v.nz = 16'(sp);
    v.px = clip16(round_q14(ct, radial));
    v.py = clip16(round_q14(-st, radial));
    v.pz = clip16(zpos);
    v.strip_end = se;
    v.mesh_end  = me;
    v.pair_last = pl;
    return v;
  endfunction

  task automatic predict_pair(logic restart);
    int unsigned nr, ns, ph;
    int cp, sp;
    longint radial, zpos;
    logic last_side, last_ring;
    nr = limit_count(rings);
    ns = limit_count(sides);
    if (restart) begin
      ring_pos = 0; side_pos = 0; cur_cos = 16384; cur_sin = 0;
    end
    if (side_pos == 0) begin
      ph = angle_of(ring_pos + 1, nr);
      nxt_cos = sine_of(ph + 16384);
      nxt_sin = sine_of(ph);
    end
    ph = angle_of(side_pos + 1, ns);
    cp = sine_of(ph + 16384);
    sp = sine_of(ph);
    radial = longint'(outer_r) + round_q14(longint'(inner_r), cp);
    zpos = round_q14(longint'(inner_r), sp);
    last_side = side_pos >= ns;
    last_ring = ring_pos + 1 >= nr;
    vertex_q.push_back(make_vertex(nxt_cos, nxt_sin, cp, sp, radial, zpos, 0, 0, 0));
    vertex_q.push_back(make_vertex(cur_cos, cur_sin, cp, sp, radial, zpos,
                                   last_side, last_side && last_ring, 1));
    if (last_side) begin
      side_pos = 0;
      cur_cos = nxt_cos;
      cur_sin = nxt_sin;
      ring_pos = last_ring ? 0 : ring_pos + 1;
    end else begin
      side_pos++;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s at vertex %0d: got %0d, expected %0d", what, vertex_count, got, want);
    fail_count++;
  endtask

  vertex_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= INNER_RESET; outer_r <= OUTER_RESET;
      sides <= SIDES_RESET; rings <= RINGS_RESET;
      ring_pos = 0; side_pos = 0;
      cur_cos = 16384; cur_sin = 0; nxt_cos = 0; nxt_sin = 0;
      vertex_q.delete();
      fail_count = 0; vertex_count = 0; mesh_count = 0;
    end else begin
      if (in_valid && in_ready) predict_pair(in_restart);
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          $display("UNEXPECTED vertex transfer with nothing predicted");
          fail_count++;
        end else begin
          want = vertex_q.pop_front();
          if (out_normal_x != want.nx) report_mismatch("normal_x", out_normal_x, want.nx);
          if (out_normal_y != want.ny) report_mismatch("normal_y", out_normal_y, want.ny);
          if (out_normal_z != want.nz) report_mismatch("normal_z", out_normal_z, want.nz);
          if (out_pos_x != want.px) report_mismatch("pos_x", out_pos_x, want.px);
          if (out_pos_y != want.py) report_mismatch("pos_y", out_pos_y, want.py);
          if (out_pos_z != want.pz) report_mismatch("pos_z", out_pos_z, want.pz);
          if (out_strip_end != want.strip_end)
            report_mismatch("strip_end", out_strip_end, want.strip_end);
          if (out_mesh_end != want.mesh_end)
            report_mismatch("mesh_end", out_mesh_end, want.mesh_end);
          if (out_pair_last != want.pair_last)
            report_mismatch("pair_last", out_pair_last, want.pair_last);
          if (want.mesh_end) mesh_count++;
        end
        vertex_count++;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_INNER: inner_r <= cfg_wdata;
          REG_OUTER: outer_r <= cfg_wdata;
          REG_SIDES: sides   <= cfg_wdata[8:0];
          REG_RINGS: rings   <= cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
  end

  assign pending = vertex_q.size();
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the torus vertex generator: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module tb_top;
  import tvg_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [14:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_restart;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic               out_strip_end, out_mesh_end, out_pair_last;

  int fail_count, pending, vertex_count, mesh_count;
  int cycle_count;
  int ticks_sent;
  int burst_left;
  // When set, the receiver holds off for a long stretch so the block backs up.
  logic hold_request;

  // Upper bound on the run. It covers the block's work on every tick at worst,
  // plus sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT = 1000000;

  torus_vertex_generator_core uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_restart,
    .out_valid, .out_ready,
    .out_normal_x, .out_normal_y, .out_normal_z,
    .out_pos_x, .out_pos_y, .out_pos_z,
    .out_strip_end, .out_mesh_end, .out_pair_last
  );

  tvg_checker vertex_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_restart,
    .out_valid, .out_ready,
    .out_normal_x, .out_normal_y, .out_normal_z,
    .out_pos_x, .out_pos_y, .out_pos_z,
    .out_strip_end, .out_mesh_end, .out_pair_last,
    .fail_count, .pending, .vertex_count, .mesh_count
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The timeout watchdog: a run that never drains is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls on its own random pattern, with calm stretches where it always
  // accepts, and stops completely for a long stretch when a hold is requested.
  initial begin : receiver
    int mode, hold_cycles;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clk);
        hold_request = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one tick and waits for its transfer. Between bursts the sender idles for a
  // random gap; valid is held high across back-to-back ticks inside a burst.
  task automatic send_tick(logic restart);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    ticks_sent++;
  endtask

  // Waits until every predicted vertex has arrived, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [14:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_shape(logic [14:0] inner, logic [14:0] outer, logic [8:0] s,
                           logic [8:0] r);
    write_reg(REG_INNER, inner);
    write_reg(REG_OUTER, outer);
    write_reg(REG_SIDES, {6'd0, s});
    write_reg(REG_RINGS, {6'd0, r});
    @(posedge clk);
  endtask

  // Random ticks: mostly plain advances through the mesh, with an occasional restart.
  task automatic random_ticks(int n);
    repeat (n) send_tick($urandom_range(0, 39) == 0);
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_INNER; cfg_wdata = '0;
    in_valid = 1'b0; in_restart = 1'b0;
    hold_request = 1'b0;
    cycle_count = 0; ticks_sent = 0; burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default shape, a restart, then a full small mesh to hit strip and mesh ends.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
    set_shape(15'd1126, 15'd3482, 9'd3, 9'd3);
    repeat (13) send_tick(1'b0);
    // Counts below and above the legal range act as clamped values.
    drain();
    set_shape(15'h7FFF, 15'h7FFF, 9'd0, 9'd1);
    repeat (6) send_tick(1'b0);
    drain();
    set_shape(15'd0, 15'd0, 9'h1FF, 9'd257);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Back-pressure: the receiver stops while the sender keeps offering ticks.
    set_shape(15'd2000, 15'd8000, 9'd5, 9'd4);
    hold_request = 1'b1;
    random_ticks(30);
    // Pause until the block has delivered everything.
    drain();

    // Random phases with random shapes, mostly small counts and a few large ones.
    repeat (14) begin
      set_shape(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                9'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                               : $urandom_range(3, 12)),
                9'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                               : $urandom_range(3, 8)));
      random_ticks(50);
      drain();
    end

    // Restore the default shape at the end.
    set_shape(INNER_RESET, OUTER_RESET, SIDES_RESET, RINGS_RESET);
    random_ticks(20);
    drain();

    $display("Covered %0d ticks, %0d vertices checked and %0d complete meshes,",
             ticks_sent, vertex_count, mesh_count);
    $display("across default, clamped, extreme and random torus shapes.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/tvg_pkg.sv
rtl/tvg_controller.sv
rtl/tvg_datapath.sv
rtl/torus_vertex_generator_core.sv
tb/sv/tvg_checker.sv
tb/sv/tb_top.sv
